FILE: src/fcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types, constants and helper functions for the corner strength unit.
// ----------------------------------------------------------------------------
package fcs_pkg;

    localparam int PIX_W      = 8;
    localparam int CIRCLE_LEN = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_MODE  = 1'd1;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd20;
    localparam logic             ARC_MODE_RESET  = 1'b0;
    localparam logic             ARC_MODE_12     = 1'b1;

    typedef logic [CIRCLE_LEN-1:0][PIX_W-1:0] t_circle;

    typedef struct packed {
        logic valid;
        logic last;
        logic mode;
    } t_ctrl;

    function automatic logic [PIX_W-1:0] f_min(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        f_min = (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] f_max(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        f_max = (a > b) ? a : b;
    endfunction

endpackage

FILE: src/fcs_diff.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_diff
// Two stages: saturated darker and brighter bounds, then the per-pixel
// saturated margins against those bounds.
// ----------------------------------------------------------------------------
module fcs_diff (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_adv,
    input  fcs_pkg::t_ctrl                 i_ctrl,
    input  wire  [fcs_pkg::PIX_W-1:0]      i_center,
    input  fcs_pkg::t_circle               i_circle,
    input  wire  [fcs_pkg::PIX_W-1:0]      i_threshold,
    output fcs_pkg::t_ctrl                 o_ctrl,
    output fcs_pkg::t_circle               o_dark,
    output fcs_pkg::t_circle               o_bright
);
    import fcs_pkg::*;

    logic [PIX_W:0]   w_dark_sum;
    logic [PIX_W:0]   w_bright_sum;
    logic [PIX_W-1:0] n_dark_bound;
    logic [PIX_W-1:0] n_bright_bound;
    logic [PIX_W-1:0] r_dark_bound;
    logic [PIX_W-1:0] r_bright_bound;
    t_circle          r_pix;
    t_ctrl            r_ctrl1;
    t_circle          n_dark;
    t_circle          n_bright;
    t_circle          r_dark;
    t_circle          r_bright;
    t_ctrl            r_ctrl2;

    assign w_dark_sum   = {1'b0, i_center} - {1'b0, i_threshold};
    assign w_bright_sum = {1'b0, i_center} + {1'b0, i_threshold};

    always_comb begin
        n_dark_bound   = w_dark_sum[PIX_W] ? '0 : w_dark_sum[PIX_W-1:0];
        n_bright_bound = w_bright_sum[PIX_W] ? '1 : w_bright_sum[PIX_W-1:0];
    end

    always_comb begin
        for (int k = 0; k < CIRCLE_LEN; k++) begin
            n_dark[4'(k)]   = (r_dark_bound > r_pix[4'(k)]) ?
                              r_dark_bound - r_pix[4'(k)] : '0;
            n_bright[4'(k)] = (r_pix[4'(k)] > r_bright_bound) ?
                              r_pix[4'(k)] - r_bright_bound : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl1 <= '0;
            r_ctrl2 <= '0;
        end else if (i_adv) begin
            r_ctrl1 <= i_ctrl;
            r_ctrl2 <= r_ctrl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dark_bound   <= n_dark_bound;
            r_bright_bound <= n_bright_bound;
            r_pix          <= i_circle;
            r_dark         <= n_dark;
            r_bright       <= n_bright;
        end
    end

    assign o_ctrl   = r_ctrl2;
    assign o_dark   = r_dark;
    assign o_bright = r_bright;

endmodule
`default_nettype wire

FILE: src/fcs_arc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_arc
// Two stages of a doubling minimum tree giving the score of every wrapping
// arc of 9 or 12 positions, for the darker and the brighter margins.
// ----------------------------------------------------------------------------
module fcs_arc (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_adv,
    input  fcs_pkg::t_ctrl     i_ctrl,
    input  fcs_pkg::t_circle   i_dark,
    input  fcs_pkg::t_circle   i_bright,
    output fcs_pkg::t_ctrl     o_ctrl,
    output fcs_pkg::t_circle   o_dark_arc,
    output fcs_pkg::t_circle   o_bright_arc
);
    import fcs_pkg::*;

    t_circle n_dark_m4;
    t_circle n_bright_m4;
    t_circle r_dark_m4;
    t_circle r_bright_m4;
    t_circle r_dark_d;
    t_circle r_bright_d;
    t_ctrl   r_ctrl3;
    t_circle n_dark_arc;
    t_circle n_bright_arc;
    t_circle r_dark_arc;
    t_circle r_bright_arc;
    t_ctrl   r_ctrl4;

    // minimum over four consecutive positions
    always_comb begin
        for (int k = 0; k < CIRCLE_LEN; k++) begin
            n_dark_m4[4'(k)] = f_min(f_min(i_dark[4'(k)], i_dark[4'(k + 1)]),
                                     f_min(i_dark[4'(k + 2)], i_dark[4'(k + 3)]));
            n_bright_m4[4'(k)] = f_min(f_min(i_bright[4'(k)], i_bright[4'(k + 1)]),
                                       f_min(i_bright[4'(k + 2)], i_bright[4'(k + 3)]));
        end
    end

    // eight from two fours, then the ninth pixel or four more
    always_comb begin
        for (int k = 0; k < CIRCLE_LEN; k++) begin
            n_dark_arc[4'(k)] = f_min(f_min(r_dark_m4[4'(k)], r_dark_m4[4'(k + 4)]),
                                      (r_ctrl3.mode == ARC_MODE_12) ?
                                      r_dark_m4[4'(k + 8)] : r_dark_d[4'(k + 8)]);
            n_bright_arc[4'(k)] = f_min(f_min(r_bright_m4[4'(k)], r_bright_m4[4'(k + 4)]),
                                        (r_ctrl3.mode == ARC_MODE_12) ?
                                        r_bright_m4[4'(k + 8)] : r_bright_d[4'(k + 8)]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl3 <= '0;
            r_ctrl4 <= '0;
        end else if (i_adv) begin
            r_ctrl3 <= i_ctrl;
            r_ctrl4 <= r_ctrl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dark_m4    <= n_dark_m4;
            r_bright_m4  <= n_bright_m4;
            r_dark_d     <= i_dark;
            r_bright_d   <= i_bright;
            r_dark_arc   <= n_dark_arc;
            r_bright_arc <= n_bright_arc;
        end
    end

    assign o_ctrl       = r_ctrl4;
    assign o_dark_arc   = r_dark_arc;
    assign o_bright_arc = r_bright_arc;

endmodule
`default_nettype wire

FILE: src/fcs_max.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_max
// Registered maximum tree over the 32 arc scores: 32 to 4, then 4 to 1.
// ----------------------------------------------------------------------------
module fcs_max (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_adv,
    input  fcs_pkg::t_ctrl               i_ctrl,
    input  fcs_pkg::t_circle             i_dark_arc,
    input  fcs_pkg::t_circle             i_bright_arc,
    output fcs_pkg::t_ctrl               o_ctrl,
    output logic [fcs_pkg::PIX_W-1:0]    o_strength
);
    import fcs_pkg::*;

    localparam int GROUPS = 4;
    localparam int GROUP_LEN = 2 * CIRCLE_LEN / GROUPS;

    logic [2*CIRCLE_LEN-1:0][PIX_W-1:0] w_all;
    logic [GROUPS-1:0][PIX_W-1:0]       n_group;
    logic [GROUPS-1:0][PIX_W-1:0]       r_group;
    t_ctrl                              r_ctrl5;
    logic [PIX_W-1:0]                   n_strength;
    logic [PIX_W-1:0]                   r_strength;
    t_ctrl                              r_ctrl6;

    assign w_all = {i_bright_arc, i_dark_arc};

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_group[2'(g)] = f_max(
                f_max(f_max(w_all[5'(g*GROUP_LEN)],     w_all[5'(g*GROUP_LEN + 1)]),
                      f_max(w_all[5'(g*GROUP_LEN + 2)], w_all[5'(g*GROUP_LEN + 3)])),
                f_max(f_max(w_all[5'(g*GROUP_LEN + 4)], w_all[5'(g*GROUP_LEN + 5)]),
                      f_max(w_all[5'(g*GROUP_LEN + 6)], w_all[5'(g*GROUP_LEN + 7)])));
        end
        n_strength = f_max(f_max(r_group[0], r_group[1]), f_max(r_group[2], r_group[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl5 <= '0;
            r_ctrl6 <= '0;
        end else if (i_adv) begin
            r_ctrl5 <= i_ctrl;
            r_ctrl6 <= r_ctrl5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_group    <= n_group;
            r_strength <= n_strength;
        end
    end

    assign o_ctrl     = r_ctrl6;
    assign o_strength = r_strength;

endmodule
`default_nettype wire

FILE: src/fcs_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcs_skid
// Output register with a skid register, so the pipeline's advance signal
// comes from a flop and not from the downstream ready.
// ----------------------------------------------------------------------------
module fcs_skid (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    input  wire                              i_last,
    input  wire  [fcs_pkg::PIX_W-1:0]        i_strength,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic                             o_last,
    output logic [fcs_pkg::PIX_W-1:0]        o_strength,
    input  wire                              i_out_ready
);
    import fcs_pkg::*;

    logic             r_out_valid;
    logic             r_out_last;
    logic [PIX_W-1:0] r_out_strength;
    logic             r_skid_valid;
    logic             r_skid_last;
    logic [PIX_W-1:0] r_skid_strength;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_last     <= r_skid_last;
                r_out_strength <= r_skid_strength;
            end else begin
                r_out_last     <= i_last;
                r_out_strength <= i_strength;
            end
        end else if (!r_skid_valid) begin
            r_skid_last     <= i_last;
            r_skid_strength <= i_strength;
        end
    end

    assign o_ready    = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_last     = r_out_last;
    assign o_strength = r_out_strength;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && i_valid && !r_skid_valid) |=> r_skid_valid)
        else $error("item arriving behind a stalled output was not caught");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid register did not move to the output");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_ready) |=> (r_skid_valid && $stable(r_skid_strength)))
        else $error("skid contents changed during a stall");

endmodule
`default_nettype wire

FILE: src/fast_corner_strength_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fast_corner_strength_unit
// FAST 9/12 corner strength per pixel: center plus 16 circle pixels in,
// one strength byte out.
// ----------------------------------------------------------------------------
// Takes one pixel item per clock while o_s_tready is high and returns one
// strength item per pixel, in order. An accepted item passes six pipeline
// stages (bounds, margins, two arc-minimum stages, two max-tree stages) and
// then the output register before it appears on the output.
// o_s_tready is the registered state of the output skid register, so a stall
// stops the whole pipeline once the skid holds an item, losing no item.
// threshold and arc_mode are written through the config port; the user must
// do so only while no item is in flight, which the block does not enforce.
module fast_corner_strength_unit (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [fcs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [fcs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // center_pixel[7:0], circle_first_half[71:8], circle_second_half[135:72]
    input  wire  [fcs_pkg::IN_DATA_W-1:0]        i_s_tdata,
    input  wire                                  i_s_tlast,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // strength[7:0]
    output logic [fcs_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    output logic                                 o_m_tlast
);
    import fcs_pkg::*;

    logic [PIX_W-1:0] r_threshold;
    logic             r_arc_mode;
    logic             w_adv;
    t_ctrl            w_in_ctrl;
    t_ctrl            w_diff_ctrl;
    t_ctrl            w_arc_ctrl;
    t_ctrl            w_max_ctrl;
    t_circle          w_circle;
    t_circle          w_dark;
    t_circle          w_bright;
    t_circle          w_dark_arc;
    t_circle          w_bright_arc;
    logic [PIX_W-1:0] w_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_arc_mode  <= ARC_MODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_ARC_MODE:  r_arc_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_s_tready = w_adv;
    assign w_circle   = i_s_tdata[IN_DATA_W-1:PIX_W];

    always_comb begin
        w_in_ctrl.valid = i_s_tvalid;
        w_in_ctrl.last  = i_s_tlast;
        w_in_ctrl.mode  = r_arc_mode;
    end

    fcs_diff u_diff (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_ctrl      (w_in_ctrl),
        .i_center    (i_s_tdata[PIX_W-1:0]),
        .i_circle    (w_circle),
        .i_threshold (r_threshold),
        .o_ctrl      (w_diff_ctrl),
        .o_dark      (w_dark),
        .o_bright    (w_bright)
    );

    fcs_arc u_arc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_ctrl       (w_diff_ctrl),
        .i_dark       (w_dark),
        .i_bright     (w_bright),
        .o_ctrl       (w_arc_ctrl),
        .o_dark_arc   (w_dark_arc),
        .o_bright_arc (w_bright_arc)
    );

    fcs_max u_max (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_ctrl       (w_arc_ctrl),
        .i_dark_arc   (w_dark_arc),
        .i_bright_arc (w_bright_arc),
        .o_ctrl       (w_max_ctrl),
        .o_strength   (w_strength)
    );

    fcs_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_max_ctrl.valid),
        .i_last      (w_max_ctrl.last),
        .i_strength  (w_strength),
        .o_ready     (w_adv),
        .o_valid     (o_m_tvalid),
        .o_last      (o_m_tlast),
        .o_strength  (o_m_tdata),
        .i_out_ready (i_m_tready)
    );

endmodule
`default_nettype wire
